### rtl/sct_pkg.sv
// Shared types, constants and character classification for the source tokenizer.
`default_nettype none
package sct_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int POS_BITS        = 16;
    localparam int WIDE_BITS       = 32;
    localparam int MAX_PUSH        = 3;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_USCR  = 8'h5F;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_DIG_0 = 8'h30;
    localparam logic [7:0] CHAR_DIG_9 = 8'h39;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_CARET = 8'h5E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_PIPE  = 8'h7C;
    localparam logic [7:0] CHAR_LPAR  = 8'h28;
    localparam logic [7:0] CHAR_RPAR  = 8'h29;
    localparam logic [7:0] CHAR_LBRK  = 8'h5B;
    localparam logic [7:0] CHAR_RBRK  = 8'h5D;
    localparam logic [7:0] CHAR_LBRC  = 8'h7B;
    localparam logic [7:0] CHAR_RBRC  = 8'h7D;

    localparam logic [2:0] CLASS_WORD    = 3'd0;
    localparam logic [2:0] CLASS_OP      = 3'd1;
    localparam logic [2:0] CLASS_COMMENT = 3'd2;
    localparam logic [2:0] CLASS_OTHER   = 3'd3;
    localparam logic [2:0] CLASS_END     = 3'd4;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_WORD  = 2'd1,
        KIND_OP    = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       final_char;
    } input_t;

    typedef struct packed {
        logic [7:0]          char_out;
        logic [2:0]          char_class;
        logic                token_start;
        logic [POS_BITS-1:0] line_number;
        logic [POS_BITS-1:0] column_number;
        logic                stream_end;
    } result_t;

    // Up to three results produced by one request, packed in order.
    typedef struct packed {
        logic [1:0]                   count;
        result_t [MAX_PUSH-1:0]       slot;
    } push_t;

    function automatic kind_t char_kind(input logic [7:0] c);
        kind_t k;
        k = KIND_NONE;
        if ((c >= CHAR_LO_A && c <= CHAR_LO_Z) || (c >= CHAR_UP_A && c <= CHAR_UP_Z) ||
            (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) || c == CHAR_USCR || c == CHAR_DOT) begin
            k = KIND_WORD;
        end else if (c == CHAR_LT || c == CHAR_GT || c == CHAR_EQ || c == CHAR_AMP ||
                     c == CHAR_STAR || c == CHAR_PLUS || c == CHAR_MINUS ||
                     c == CHAR_BANG || c == CHAR_CARET || c == CHAR_SLASH) begin
            k = KIND_OP;
        end else if (c == CHAR_COLON || c == CHAR_SEMI || c == CHAR_QUOTE ||
                     c == CHAR_PIPE || c == CHAR_LPAR || c == CHAR_RPAR ||
                     c == CHAR_LBRK || c == CHAR_RBRK || c == CHAR_LBRC ||
                     c == CHAR_RBRC) begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

    // Positions are reported on 16 bits and stick at all ones.
    function automatic logic [POS_BITS-1:0] clamp_pos(input logic [WIDE_BITS-1:0] v);
        logic [POS_BITS-1:0] r;
        r = (|v[WIDE_BITS-1:POS_BITS]) ? {POS_BITS{1'b1}} : v[POS_BITS-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/sct_core.sv
// Input register, lookahead state and per-character classification.
`default_nettype none
module sct_core #(
    parameter int LINE_BITS   = sct_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = sct_pkg::COLUMN_BITS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire sct_pkg::input_t s_data,
    input  wire logic            room,
    output sct_pkg::push_t       push
);

    localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

    logic                   in_valid_reg;
    sct_pkg::input_t        in_data_reg;
    logic [7:0]             held_char_reg,   held_char_next;
    logic                   held_valid_reg,  held_valid_next;
    logic [COLUMN_BITS-1:0] held_column_reg, held_column_next;
    logic [COLUMN_BITS-1:0] column_count_reg, column_count_next;
    logic [LINE_BITS-1:0]   row_count_reg,   row_count_next;
    logic                   word_open_reg,   word_open_next;

    logic                   advance;
    logic [7:0]             c;
    logic                   fin;
    logic                   sep;
    logic [7:0]             la;
    sct_pkg::kind_t         hk;
    sct_pkg::kind_t         ck;
    logic                   cons;
    logic                   wo;
    logic [15:0]            line_out;
    logic [15:0]            held_col_out;
    logic [15:0]            cc_out;
    logic [COLUMN_BITS-1:0] cc_new;
    logic [LINE_BITS-1:0]   line_new;
    sct_pkg::result_t       cand [4];
    logic [3:0]             cv;
    logic [2:0]             n;

    assign advance = in_valid_reg && room;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        c   = in_data_reg.char_in;
        fin = in_data_reg.final_char;
        sep = (c == sct_pkg::CHAR_NL) || (c == sct_pkg::CHAR_SP);
        la  = sep ? sct_pkg::CHAR_NUL : c;
        hk  = sct_pkg::char_kind(held_char_reg);
        ck  = sct_pkg::char_kind(c);
        line_out     = sct_pkg::clamp_pos(sct_pkg::WIDE_BITS'(row_count_reg));
        held_col_out = sct_pkg::clamp_pos(sct_pkg::WIDE_BITS'(held_column_reg));
        cc_out       = sct_pkg::clamp_pos(sct_pkg::WIDE_BITS'(column_count_reg));

        if (c == sct_pkg::CHAR_NL) begin
            cc_new   = '0;
            line_new = (row_count_reg != LINE_MAX) ? row_count_reg + LINE_ONE
                                                   : row_count_reg;
        end else begin
            cc_new   = (column_count_reg != COL_MAX) ? column_count_reg + COLUMN_BITS'(1)
                                                     : column_count_reg;
            line_new = row_count_reg;
        end

        cv   = '0;
        cons = 1'b0;
        wo   = word_open_reg;

        // Held character, second half of a pair comes from the lookahead
        cand[0] = '{char_out: held_char_reg, char_class: sct_pkg::CLASS_WORD,
                    token_start: 1'b1, line_number: line_out,
                    column_number: held_col_out, stream_end: 1'b0};
        cand[1] = '{char_out: la, char_class: sct_pkg::CLASS_OP, token_start: 1'b0,
                    line_number: line_out, column_number: cc_out, stream_end: 1'b0};
        if (held_valid_reg) begin
            if (hk == sct_pkg::KIND_WORD) begin
                cv[0] = 1'b1;
                cand[0].token_start = !wo;
                wo = 1'b1;
            end else if ((held_char_reg == sct_pkg::CHAR_SLASH &&
                          (la == sct_pkg::CHAR_SLASH || la == sct_pkg::CHAR_STAR)) ||
                         (held_char_reg == sct_pkg::CHAR_STAR &&
                          la == sct_pkg::CHAR_SLASH)) begin
                cv[0] = 1'b1;
                cv[1] = 1'b1;
                cand[0].char_class = sct_pkg::CLASS_COMMENT;
                cand[1].char_class = sct_pkg::CLASS_COMMENT;
                cons = 1'b1;
                wo = 1'b0;
            end else if (hk == sct_pkg::KIND_OP) begin
                cv[0] = 1'b1;
                cand[0].char_class = sct_pkg::CLASS_OP;
                wo = 1'b0;
                if (la == sct_pkg::CHAR_EQ) begin
                    cv[1] = 1'b1;
                    cons = 1'b1;
                end
            end else if (hk == sct_pkg::KIND_OTHER) begin
                cv[0] = 1'b1;
                cand[0].char_class = sct_pkg::CLASS_OTHER;
                wo = 1'b0;
            end
        end

        if (sep) begin
            wo = 1'b0;
        end

        // Final byte is emitted right away with empty lookahead
        cand[2] = '{char_out: c, char_class: sct_pkg::CLASS_WORD, token_start: 1'b1,
                    line_number: line_out, column_number: cc_out, stream_end: 1'b0};
        if (!sep && !cons && fin) begin
            case (ck)
                sct_pkg::KIND_WORD: begin
                    cv[2] = 1'b1;
                    cand[2].token_start = !wo;
                end
                sct_pkg::KIND_OP: begin
                    cv[2] = 1'b1;
                    cand[2].char_class = sct_pkg::CLASS_OP;
                end
                sct_pkg::KIND_OTHER: begin
                    cv[2] = 1'b1;
                    cand[2].char_class = sct_pkg::CLASS_OTHER;
                end
                default: begin
                    cv[2] = 1'b0;
                end
            endcase
        end

        cand[3] = '{char_out: sct_pkg::CHAR_NUL, char_class: sct_pkg::CLASS_END,
                    token_start: 1'b0,
                    line_number: sct_pkg::clamp_pos(sct_pkg::WIDE_BITS'(line_new)),
                    column_number: sct_pkg::clamp_pos(sct_pkg::WIDE_BITS'(cc_new)),
                    stream_end: 1'b1};
        cv[3] = fin;

        push.slot = '0;
        n = '0;
        for (int k = 0; k < 4; k++) begin
            if (cv[k] && n < 3'(sct_pkg::MAX_PUSH)) begin
                push.slot[n[1:0]] = cand[k];
                n = n + 3'd1;
            end
        end
        push.count = advance ? n[1:0] : 2'd0;

        if (fin) begin
            held_char_next    = sct_pkg::CHAR_NUL;
            held_valid_next   = 1'b0;
            held_column_next  = '0;
            column_count_next = '0;
            row_count_next    = LINE_ONE;
            word_open_next    = 1'b0;
        end else begin
            held_char_next    = c;
            held_valid_next   = !sep && !cons;
            held_column_next  = column_count_reg;
            column_count_next = cc_new;
            row_count_next    = line_new;
            word_open_next    = wo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            held_valid_reg   <= 1'b0;
            column_count_reg <= '0;
            row_count_reg    <= LINE_ONE;
            word_open_reg    <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                held_valid_reg   <= held_valid_next;
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
                word_open_reg    <= word_open_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            held_char_reg   <= held_char_next;
            held_column_reg <= held_column_next;
        end
    end

endmodule
`default_nettype wire

### rtl/sct_queue.sv
// Small result queue: takes up to three results a cycle, hands out one.
`default_nettype none
module sct_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire sct_pkg::push_t   push,
    output logic                  room,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output sct_pkg::result_t      m_data
);

    localparam int PTR_BITS = $clog2(sct_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(sct_pkg::QUEUE_DEPTH + 1);

    sct_pkg::result_t      q_reg [sct_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg,  count_next;
    logic                  pop;

    // Room is judged on the registered fill so ready never waits on m_ready.
    assign room    = count_reg <= CNT_BITS'(sct_pkg::QUEUE_DEPTH - sct_pkg::MAX_PUSH);
    assign m_valid = count_reg != '0;
    assign m_data  = q_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < sct_pkg::MAX_PUSH; k++) begin
            if (2'(k) < push.count) begin
                q_reg[wr_ptr_reg + PTR_BITS'(k)] <= push.slot[k];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/source_char_tokenizer.sv
// Top level of the source character tokenizer.
`default_nettype none
// Takes one source byte per request and returns one result per kept character,
// each with its class, token-start flag, line and column, plus an end marker
// after the byte flagged final. One byte is held back as lookahead, so a
// character other than the final byte comes out when the byte after it
// arrives. A byte is accepted every cycle while the result queue holds at
// most one entry; the four-entry result queue absorbs the two or three
// results of a byte that produces them (a two-character token, or the
// final byte).
module source_char_tokenizer #(
    parameter int LINE_BITS   = sct_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = sct_pkg::COLUMN_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire sct_pkg::input_t  s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output sct_pkg::result_t      m_data
);

    sct_pkg::push_t push;
    logic           room;

    sct_core #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .room    (room),
        .push    (push)
    );

    sct_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
